[src/tal_pkg.sv]
`timescale 1ns / 1ps

package tal_pkg;

  localparam int DEF_MAX_TRIANGLES = 1024;
  localparam int DEF_MAX_VERTICES  = 1024;
  localparam int VTX_W             = 10;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef logic [VTX_W-1:0]        vtx_t;
  typedef logic [2:0][VTX_W-1:0]   triple_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_NOT_LOADED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_QRY_TRI,
    ST_QRY_HEAD,
    ST_QRY_LINK,
    ST_QRY_CHK,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e        op;
    triple_t    vtx;
    logic [2:0] vtx_ok;
    vtx_t       query_triangle;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

  typedef struct packed {
    status_e               status;
    vtx_t                  assigned;
    logic [2:0][VTX_W-1:0] nb;
    logic [2:0]            fd;
  } res_t;

  function automatic vtx_t pick(triple_t t, logic [1:0] i);
    case (i)
      2'd0:    return t[0];
      2'd1:    return t[1];
      default: return t[2];
    endcase
  endfunction

  // corner that follows i around the triangle
  function automatic logic [1:0] next_corner(logic [1:0] i);
    case (i)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

endpackage

[src/tal_front.sv]
`timescale 1ns / 1ps

module tal_front #(
  parameter int MAX_VERTICES = tal_pkg::DEF_MAX_VERTICES
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  tal_pkg::vtx_t      vertex_a_i,
  input  tal_pkg::vtx_t      vertex_b_i,
  input  tal_pkg::vtx_t      vertex_c_i,
  input  tal_pkg::vtx_t      query_triangle_i,
  input  logic               q_full_i,
  input  logic               init_busy_i,
  output tal_pkg::cmd_beat_t push_o
);

  tal_pkg::op_e op;

  always_comb begin
    case (kind_i)
      tal_pkg::KIND_LOAD:  op = tal_pkg::OP_LOAD;
      tal_pkg::KIND_QUERY: op = tal_pkg::OP_QUERY;
      tal_pkg::KIND_CLEAR: op = tal_pkg::OP_CLEAR;
      default:             op = tal_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o = q_full_i || init_busy_i;

  always_comb begin
    push_o.valid              = in_valid_i && !in_stall_o;
    push_o.cmd.op             = op;
    push_o.cmd.vtx            = {vertex_c_i, vertex_b_i, vertex_a_i};
    // vertices outside the table never enter or search a list
    push_o.cmd.vtx_ok[0]      = 32'(vertex_a_i) < MAX_VERTICES;
    push_o.cmd.vtx_ok[1]      = 32'(vertex_b_i) < MAX_VERTICES;
    push_o.cmd.vtx_ok[2]      = 32'(vertex_c_i) < MAX_VERTICES;
    push_o.cmd.query_triangle = query_triangle_i;
  end

endmodule

[src/tal_fifo.sv]
`timescale 1ns / 1ps

module tal_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tal_pkg::cmd_beat_t push_i,
  output logic               full_o,
  input  logic               pop_i,
  output tal_pkg::cmd_beat_t head_o
);

  localparam int PW = (tal_pkg::QUEUE_DEPTH > 1) ? $clog2(tal_pkg::QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(tal_pkg::QUEUE_DEPTH + 1);

  tal_pkg::cmd_t mem_q [tal_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          do_push, do_pop;

  assign full_o      = fill_q == FW'(tal_pkg::QUEUE_DEPTH);
  assign head_o.valid = fill_q != '0;
  assign head_o.cmd   = mem_q[rd_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(tal_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(tal_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

endmodule

[src/tal_back.sv]
`timescale 1ns / 1ps

module tal_back #(
  parameter int MAX_TRIANGLES = tal_pkg::DEF_MAX_TRIANGLES,
  parameter int MAX_VERTICES  = tal_pkg::DEF_MAX_VERTICES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tal_pkg::cmd_beat_t head_i,
  output logic               pop_o,
  output logic               init_busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tal_pkg::res_t      out_o
);

  localparam int TW         = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CW         = $clog2(MAX_TRIANGLES + 1);
  localparam int EDGE_CODES = 3 * MAX_TRIANGLES;
  localparam int EW         = $clog2(EDGE_CODES);
  localparam int VW         = $clog2(MAX_VERTICES);

  typedef struct packed {
    logic          valid;
    logic [TW-1:0] tidx;
    logic [1:0]    e;
  } link_t;

  // memories
  tal_pkg::triple_t store_mem [MAX_TRIANGLES];
  link_t            head_mem  [MAX_VERTICES];
  link_t            nxt_mem   [EDGE_CODES];

  tal_pkg::triple_t store_rd_q;
  link_t            head_rd_q, nxt_rd_q;

  logic             store_we, store_re;
  logic [TW-1:0]    store_wa, store_ra;
  tal_pkg::triple_t store_wd;
  logic             head_we, head_re;
  logic [VW-1:0]    head_wa, head_ra;
  link_t            head_wd;
  logic             nxt_we, nxt_re;
  logic [EW-1:0]    nxt_wa, nxt_ra;
  link_t            nxt_wd;

  // control and datapath
  tal_pkg::state_e  state_q, state_d;
  logic [VW-1:0]    clr_q, clr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [1:0]       edge_q, edge_d;
  logic             out_valid_q, out_valid_d;
  tal_pkg::cmd_t    cmd_q, cmd_d;
  tal_pkg::triple_t tri_q, tri_d;
  link_t            cur_q, cur_d;
  tal_pkg::res_t    res_q, res_d;
  tal_pkg::res_t    out_q, out_d;

  tal_pkg::vtx_t    cur_vtx, from_v, to_v;
  logic             cur_ok, from_ok, last_edge, out_free, clr_last;
  logic             full, q_bad, match;
  link_t            cand;
  logic [EW-1:0]    load_code, walk_code;

  assign cur_vtx   = cmd_q.vtx[edge_q];
  assign cur_ok    = cmd_q.vtx_ok[edge_q];
  // edge u->v of the query triangle is matched by v->u on the list of v
  assign from_v    = tal_pkg::pick(tri_q, tal_pkg::next_corner(edge_q));
  assign to_v      = tal_pkg::pick(tri_q, edge_q);
  assign from_ok   = 32'(from_v) < MAX_VERTICES;
  assign last_edge = edge_q == 2'd2;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign clr_last  = clr_q == VW'(MAX_VERTICES - 1);
  assign full      = cnt_q == CW'(MAX_TRIANGLES);
  assign q_bad     = 32'(head_i.cmd.query_triangle) >= 32'(cnt_q);
  assign cand      = (state_q == tal_pkg::ST_QRY_LINK) ? head_rd_q : nxt_rd_q;
  assign match     = (tal_pkg::pick(store_rd_q, cur_q.e) == from_v) &&
                     (tal_pkg::pick(store_rd_q, tal_pkg::next_corner(cur_q.e)) == to_v);
  assign load_code = EW'(32'(cnt_q[TW-1:0]) * 3 + 32'(edge_q));
  assign walk_code = EW'(32'(cand.tidx) * 3 + 32'(cand.e));

  assign init_busy_o = state_q == tal_pkg::ST_INIT;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tal_pkg::ST_INIT: begin
        if (clr_last) state_d = tal_pkg::ST_IDLE;
      end
      tal_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          case (head_i.cmd.op)
            tal_pkg::OP_LOAD:  state_d = full ? tal_pkg::ST_DONE : tal_pkg::ST_LOAD_RD;
            tal_pkg::OP_QUERY: state_d = q_bad ? tal_pkg::ST_DONE : tal_pkg::ST_QRY_TRI;
            tal_pkg::OP_CLEAR: state_d = tal_pkg::ST_CLEAR;
            default:           state_d = tal_pkg::ST_DONE;
          endcase
        end
      end
      tal_pkg::ST_LOAD_RD: begin
        if (cur_ok) state_d = tal_pkg::ST_LOAD_WR;
        else if (last_edge) state_d = tal_pkg::ST_DONE;
      end
      tal_pkg::ST_LOAD_WR: begin
        state_d = last_edge ? tal_pkg::ST_DONE : tal_pkg::ST_LOAD_RD;
      end
      tal_pkg::ST_QRY_TRI: state_d = tal_pkg::ST_QRY_HEAD;
      tal_pkg::ST_QRY_HEAD: begin
        if (from_ok) state_d = tal_pkg::ST_QRY_LINK;
        else if (last_edge) state_d = tal_pkg::ST_DONE;
      end
      tal_pkg::ST_QRY_LINK, tal_pkg::ST_QRY_CHK: begin
        if ((state_q == tal_pkg::ST_QRY_CHK && match) || !cand.valid) begin
          state_d = last_edge ? tal_pkg::ST_DONE : tal_pkg::ST_QRY_HEAD;
        end else begin
          state_d = tal_pkg::ST_QRY_CHK;
        end
      end
      tal_pkg::ST_CLEAR: begin
        if (clr_last) state_d = tal_pkg::ST_DONE;
      end
      tal_pkg::ST_DONE: begin
        if (out_free) state_d = tal_pkg::ST_IDLE;
      end
      default: state_d = tal_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    edge_d      = edge_q;
    cmd_d       = cmd_q;
    tri_d       = tri_q;
    cur_d       = cur_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    store_we    = 1'b0;
    store_wa    = cnt_q[TW-1:0];
    store_wd    = head_i.cmd.vtx;
    store_re    = 1'b0;
    store_ra    = TW'(head_i.cmd.query_triangle);
    head_we     = 1'b0;
    head_wa     = VW'(cur_vtx);
    head_wd     = '{valid: 1'b1, tidx: cnt_q[TW-1:0], e: edge_q};
    head_re     = 1'b0;
    head_ra     = VW'(cur_vtx);
    nxt_we      = 1'b0;
    nxt_wa      = load_code;
    nxt_wd      = head_rd_q;
    nxt_re      = 1'b0;
    nxt_ra      = walk_code;
    case (state_q)
      tal_pkg::ST_INIT, tal_pkg::ST_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_q;
        head_wd = '0;
        clr_d   = clr_last ? '0 : clr_q + VW'(1);
      end
      tal_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o  = 1'b1;
          cmd_d  = head_i.cmd;
          edge_d = 2'd0;
          res_d  = '0;
          case (head_i.cmd.op)
            tal_pkg::OP_LOAD: begin
              if (full) begin
                res_d.status = tal_pkg::STATUS_FULL;
              end else begin
                res_d.assigned = tal_pkg::VTX_W'(cnt_q);
                store_we       = 1'b1;
              end
            end
            tal_pkg::OP_QUERY: begin
              if (q_bad) res_d.status = tal_pkg::STATUS_NOT_LOADED;
              else store_re = 1'b1;
            end
            tal_pkg::OP_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      tal_pkg::ST_LOAD_RD: begin
        if (cur_ok) head_re = 1'b1;
        else if (last_edge) cnt_d = cnt_q + CW'(1);
        else edge_d = edge_q + 2'd1;
      end
      tal_pkg::ST_LOAD_WR: begin
        // push onto the front of the start vertex list
        nxt_we  = 1'b1;
        head_we = 1'b1;
        if (last_edge) cnt_d = cnt_q + CW'(1);
        else edge_d = edge_q + 2'd1;
      end
      tal_pkg::ST_QRY_TRI: tri_d = store_rd_q;
      tal_pkg::ST_QRY_HEAD: begin
        head_ra = VW'(from_v);
        if (from_ok) head_re = 1'b1;
        else if (!last_edge) edge_d = edge_q + 2'd1;
      end
      tal_pkg::ST_QRY_LINK, tal_pkg::ST_QRY_CHK: begin
        store_ra = cand.tidx;
        if (state_q == tal_pkg::ST_QRY_CHK && match) begin
          res_d.nb[edge_q] = tal_pkg::VTX_W'(cur_q.tidx);
          res_d.fd[edge_q] = 1'b1;
          if (!last_edge) edge_d = edge_q + 2'd1;
        end else if (!cand.valid) begin
          if (!last_edge) edge_d = edge_q + 2'd1;
        end else begin
          store_re = 1'b1;
          nxt_re   = 1'b1;
          cur_d    = cand;
        end
      end
      tal_pkg::ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tal_pkg::ST_INIT;
      clr_q       <= '0;
      cnt_q       <= '0;
      edge_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      edge_q      <= edge_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    tri_q <= tri_d;
    cur_q <= cur_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store_mem[store_wa] <= store_wd;
    if (store_re) store_rd_q <= store_mem[store_ra];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (nxt_re) nxt_rd_q <= nxt_mem[nxt_ra];
  end

endmodule

[src/triangle_adjacency_edge_lists.sv]
// one item at a time: a load reads the head of each in-range vertex, then pushes onto it
// and skips the others; a query reads its triangle, then per edge with an in-range end
// vertex reads the head, takes a first look and walks the list entry by entry; a clear
// writes all MAX_VERTICES heads, one per cycle; other beats go straight to their result
// a two-beat queue takes input beats while the back end works, a result register frees it
// after reset the vertex heads are swept empty, one per cycle, with input stalled
`timescale 1ns / 1ps

module triangle_adjacency_edge_lists #(
  parameter int MAX_TRIANGLES = tal_pkg::DEF_MAX_TRIANGLES,
  parameter int MAX_VERTICES  = tal_pkg::DEF_MAX_VERTICES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [9:0] vertex_a_i,
  input  logic [9:0] vertex_b_i,
  input  logic [9:0] vertex_c_i,
  input  logic [9:0] query_triangle_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [9:0] assigned_index_o,
  output logic [9:0] neighbour_0_o,
  output logic       found_0_o,
  output logic [9:0] neighbour_1_o,
  output logic       found_1_o,
  output logic [9:0] neighbour_2_o,
  output logic       found_2_o
);

  tal_pkg::cmd_beat_t push, head;
  tal_pkg::res_t      res;
  logic               q_full, pop, init_busy;

  tal_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .vertex_a_i      (vertex_a_i),
    .vertex_b_i      (vertex_b_i),
    .vertex_c_i      (vertex_c_i),
    .query_triangle_i(query_triangle_i),
    .q_full_i        (q_full),
    .init_busy_i     (init_busy),
    .push_o          (push)
  );

  tal_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .full_o(q_full),
    .pop_i (pop),
    .head_o(head)
  );

  tal_back #(
    .MAX_TRIANGLES(MAX_TRIANGLES),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .init_busy_o(init_busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (res)
  );

  assign status_o         = res.status;
  assign assigned_index_o = res.assigned;
  assign neighbour_0_o    = res.nb[0];
  assign found_0_o        = res.fd[0];
  assign neighbour_1_o    = res.nb[1];
  assign found_1_o        = res.fd[1];
  assign neighbour_2_o    = res.nb[2];
  assign found_2_o        = res.fd[2];

endmodule
